// ===== rtl/aeoa_pkg.sv =====
package aeoa_pkg;

	// bytes reserved after each placed entry
	localparam int unsigned TRAILER_BYTES = 8;

	// duplicate marker inside a size word
	localparam logic [31:0] DUP_FLAG = 32'h0200_0000;

	// header table: one 16-byte unit per entry plus one leading unit
	localparam int unsigned HDR_UNIT_LOG2 = 4;

	// configuration field widths
	localparam int unsigned ALIGN_BITS = 4;
	localparam int unsigned COUNT_BITS = 20;
	localparam int unsigned CFG_DATA_BITS = 20;
	localparam int unsigned CFG_INDEX_BITS = 2;

	// register reset values
	localparam logic [ALIGN_BITS-1:0] ALIGN_RESET = 4'd11;
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = '0;

	// register indexes on the configuration channel
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_ALIGN_LOG2  = 2'd0,
		CFG_ENTRY_COUNT = 2'd1,
		CFG_KEEP_RAW    = 2'd2
	} cfg_idx_t;

	// configuration register contents
	typedef struct packed {
		logic [ALIGN_BITS-1:0] alignment_log2;
		logic [COUNT_BITS-1:0] entry_count;
		logic                  keep_raw_copy;
	} cfg_t;

endpackage

// ===== rtl/aeoa_cfg.sv =====
module aeoa_cfg #(
	parameter int unsigned ADDRESS_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [aeoa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [aeoa_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output aeoa_pkg::cfg_t                        cfg,
	output logic [ADDRESS_BITS-1:0]               lo_mask,
	output logic [ADDRESS_BITS-1:0]               hdr_end
);
	import aeoa_pkg::*;

	localparam int unsigned HDR_W = COUNT_BITS + 1 + HDR_UNIT_LOG2;

	cfg_t                      cfg_q;
	logic [ADDRESS_BITS-1:0]   hdr_end_q;
	logic [COUNT_BITS:0]       units;
	logic [HDR_W-1:0]          hdr_bytes;
	logic [ADDRESS_BITS-1:0]   hdr_end_d;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alignment_log2 <= ALIGN_RESET;
			cfg_q.entry_count    <= COUNT_RESET;
			cfg_q.keep_raw_copy  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ALIGN_LOG2:  cfg_q.alignment_log2 <= cfg_data[ALIGN_BITS-1:0];
				CFG_ENTRY_COUNT: cfg_q.entry_count    <= cfg_data[COUNT_BITS-1:0];
				CFG_KEEP_RAW:    cfg_q.keep_raw_copy  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// alignment low-bit mask
	assign lo_mask = (ADDRESS_BITS'(1) << cfg_q.alignment_log2) - ADDRESS_BITS'(1);

	// aligned end of the header table
	assign units     = {1'b0, cfg_q.entry_count} + (COUNT_BITS+1)'(1);
	assign hdr_bytes = {units, {HDR_UNIT_LOG2{1'b0}}};
	assign hdr_end_d = (ADDRESS_BITS'(hdr_bytes) + lo_mask) & ~lo_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_end_q <= '0;
		end else begin
			hdr_end_q <= hdr_end_d;
		end
	end

	assign cfg     = cfg_q;
	assign hdr_end = hdr_end_q;

endmodule

// ===== rtl/archive_entry_offset_assigner.sv =====
// channel   direction  payload
// s_*       in         tdata {packed_size, raw_size, orig_offset}, tuser {restart, is_new_file}
// m_*       out        tdata {next_address, size_word, data_offset}, tuser {duplicate}
// cfg_*     in         cfg_index, cfg_data (register write)
//
// one entry per cycle unless m_tready stalls; entries pass stage 1, then the result register
// the running-address loop (two aligned adds) feeds back into run_addr_q combinationally
// reset clears the pipeline valids and forgets the previous entry
// a stall on the m side holds both stages; s_tready follows m_tready combinationally
module archive_entry_offset_assigner #(
	parameter int unsigned ADDRESS_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [95:0]                           s_tdata,   // orig_offset, raw_size, packed_size
	input  logic [1:0]                            s_tuser,   // is_new_file, restart
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [95:0]                           m_tdata,   // data_offset, size_word, next_address
	output logic [0:0]                            m_tuser,   // duplicate
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [aeoa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [aeoa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import aeoa_pkg::*;

	localparam int unsigned AW = ADDRESS_BITS;

	cfg_t           cfg;
	logic [AW-1:0]  lo_mask;
	logic [AW-1:0]  hdr_end;

	// input fields
	logic [31:0]    in_orig;
	logic [31:0]    in_raw;
	logic [31:0]    in_packed;
	logic [31:0]    in_comp;
	logic [31:0]    in_stored;

	// stage 1
	logic           valid_s1;
	logic [31:0]    orig_s1;
	logic           new_file_s1;
	logic           restart_s1;
	logic [31:0]    packed_s1;
	logic [AW-1:0]  ext1_s1;
	logic [AW-1:0]  ext2_s1;
	logic           raw_adv_s1;

	// stage 2 (result register)
	logic           valid_s2;
	logic [31:0]    data_offset_s2;
	logic [31:0]    size_word_s2;
	logic           dup_s2;
	logic [31:0]    next_addr_s2;

	// previous-entry state
	logic           have_prev_q;
	logic [31:0]    prev_orig_q;
	logic [AW-1:0]  prev_off_q;
	logic [31:0]    prev_size_q;
	logic [AW-1:0]  run_addr_q;

	// placement logic
	logic           s2_free;
	logic           go_s1;
	logic           first;
	logic           dup;
	logic [AW-1:0]  base;
	logic [AW-1:0]  addr_a;
	logic [AW-1:0]  addr_b;
	logic [AW-1:0]  new_addr;
	logic [AW-1:0]  data_offset;
	logic [31:0]    size_word;

	aeoa_cfg #(
		.ADDRESS_BITS (AW)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.lo_mask   (lo_mask),
		.hdr_end   (hdr_end)
	);

	// flow control
	assign s2_free  = !valid_s2 || m_tready;
	assign go_s1    = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	// per-entry increments, independent of the running address
	assign in_orig   = s_tdata[31:0];
	assign in_raw    = s_tdata[63:32];
	assign in_packed = s_tdata[95:64];
	assign in_comp   = in_packed & ~DUP_FLAG;
	assign in_stored = (in_comp != '0) ? in_comp : in_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			orig_s1     <= in_orig;
			new_file_s1 <= s_tuser[0];
			restart_s1  <= s_tuser[1];
			packed_s1   <= in_packed;
			ext1_s1     <= AW'(in_stored) + AW'(TRAILER_BYTES) + lo_mask;
			ext2_s1     <= AW'(in_raw) + lo_mask;
			raw_adv_s1  <= cfg.keep_raw_copy && (in_comp != '0);
		end
	end

	// duplicate detection and address advance
	assign first  = restart_s1 || !have_prev_q;
	assign dup    = !first && !new_file_s1 && (prev_orig_q == orig_s1);
	assign base   = first ? hdr_end : run_addr_q;
	assign addr_a = (base + ext1_s1) & ~lo_mask;
	assign addr_b = raw_adv_s1 ? ((addr_a + ext2_s1) & ~lo_mask) : addr_a;

	assign new_addr    = dup ? run_addr_q : addr_b;
	assign data_offset = dup ? prev_off_q : base;
	assign size_word   = dup ? (prev_size_q | DUP_FLAG) : packed_s1;

	// previous-entry state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
			prev_orig_q <= '0;
			prev_off_q  <= '0;
			prev_size_q <= '0;
			run_addr_q  <= '0;
		end else if (go_s1) begin
			have_prev_q <= 1'b1;
			prev_orig_q <= orig_s1;
			prev_off_q  <= data_offset;
			prev_size_q <= size_word;
			run_addr_q  <= new_addr;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			data_offset_s2 <= 32'(data_offset);
			size_word_s2   <= size_word;
			dup_s2         <= dup;
			next_addr_s2   <= 32'(new_addr);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {next_addr_s2, size_word_s2, data_offset_s2};
	assign m_tuser  = dup_s2;

`ifndef SYNTHESIS
	// a duplicate always carries the flag in its size word
	a_dup_flag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && dup_s2 |-> (size_word_s2 & DUP_FLAG) == DUP_FLAG)
		else $error("duplicate result without flag");

	// the first entry of an archive is never a duplicate
	a_first_not_dup: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && first |-> !dup)
		else $error("duplicate flagged on first entry");

	// a placed entry leaves the running address on an alignment boundary
	a_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !dup_s2 |-> (next_addr_s2 & 32'(lo_mask)) == '0)
		else $error("unaligned running address");

	// a duplicate leaves the running address alone
	a_dup_hold: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && dup |=> run_addr_q == $past(run_addr_q))
		else $error("running address moved on duplicate");

	// a stalled stage 1 keeps its entry
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1 && $stable(orig_s1) && $stable(ext1_s1))
		else $error("stage 1 lost entry under stall");
`endif

endmodule
